// ===== hw/rtl/lpsob_pkg.sv =====
// Shared types, constants and arithmetic helpers for the layer pixel blend block.
// No dependencies; imported by every module of the block.
package lpsob_pkg;

  localparam int DEF_MAX_DIM = 4096;
  localparam int COORD_W     = 12;
  localparam int CFG_W       = 13;
  localparam int TGT_W       = 14;
  localparam int PIX_W       = 32;
  localparam int ADDR_W      = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hff000000;
  localparam logic [7:0]       CHAN_MAX   = 8'hff;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OFFSET_COL    = 2'd0,
    CFG_OFFSET_ROW    = 2'd1,
    CFG_CANVAS_WIDTH  = 2'd2,
    CFG_CANVAS_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] layer_row;
    logic [COORD_W-1:0] layer_col;
    logic [PIX_W-1:0]   layer_pixel;
    logic [PIX_W-1:0]   canvas_pixel;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic              out_of_range;
    logic [ADDR_W-1:0] canvas_address;
    logic [PIX_W-1:0]  blended_pixel;
  } out_item_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== hw/rtl/lpsob_blend.sv =====
// Source-over blend of one RGBA8 pixel onto another, four byte lanes in parallel.
// Depends on lpsob_pkg for the pixel width and the divide-by-255 helper.
module lpsob_blend
  import lpsob_pkg::*;
(
  input  logic [PIX_W-1:0] src,
  input  logic [PIX_W-1:0] dst,
  output logic [PIX_W-1:0] pix
);

  logic [7:0] inv;

  assign inv = CHAN_MAX - src[PIX_W-1 -: 8];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [15:0] prod;
    logic [7:0]  part;
    logic [8:0]  sum;

    assign prod = {8'd0, dst[8*k +: 8]} * {8'd0, inv};
    assign part = div255(prod);
    assign sum  = {1'b0, src[8*k +: 8]} + {1'b0, part};
    assign pix[8*k +: 8] = sum[8] ? CHAN_MAX : sum[7:0];
  end

endmodule

// ===== hw/rtl/lpsob_target.sv =====
// Maps a layer position to a canvas position, checks it against the canvas and
// forms the linear canvas address. Depends on lpsob_pkg for field widths.
module lpsob_target
  import lpsob_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic [COORD_W-1:0]      layer_row,
  input  logic [COORD_W-1:0]      layer_col,
  input  logic signed [CFG_W-1:0] offset_row,
  input  logic signed [CFG_W-1:0] offset_col,
  input  logic [CFG_W-1:0]        canvas_width,
  input  logic [CFG_W-1:0]        canvas_height,
  output logic                    out_of_range,
  output logic [ADDR_W-1:0]       canvas_address
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int PROD_W = CFG_W + DIM_W;
  localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

  logic [DIM_W-1:0]        w_sat;
  logic [DIM_W-1:0]        h_sat;
  logic signed [TGT_W-1:0] trow;
  logic signed [TGT_W-1:0] tcol;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        sum;

  assign w_sat = (32'(canvas_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(canvas_width);
  assign h_sat = (32'(canvas_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(canvas_height);

  assign trow = {offset_row[CFG_W-1], offset_row} + $signed({2'b00, layer_row});
  assign tcol = {offset_col[CFG_W-1], offset_col} + $signed({2'b00, layer_col});

  assign out_of_range = trow[TGT_W-1] || tcol[TGT_W-1] ||
                        (CMP_W'(trow[CFG_W-1:0]) >= CMP_W'(h_sat)) ||
                        (CMP_W'(tcol[CFG_W-1:0]) >= CMP_W'(w_sat));

  assign prod = PROD_W'(trow[CFG_W-1:0]) * PROD_W'(w_sat);
  assign sum  = SUM_W'(prod) + SUM_W'(tcol[CFG_W-1:0]);

  assign canvas_address = out_of_range ? '0 : ADDR_W'(sum);

endmodule

// ===== hw/rtl/layer_pixel_source_over_blend.sv =====
// Top level of the layer pixel source-over blend block.
// Depends on lpsob_pkg, lpsob_target and lpsob_blend.
//
// Each transfer on the input channel carries one layer pixel, its row and column
// within the layer, and the canvas pixel already read at the target spot. One result
// transfer follows each input: the canvas address, a write enable that is set when the
// layer alpha is nonzero and the target lies on the canvas, an out-of-range flag, and
// the source-over pixel (the canvas pixel unchanged when nothing is written). The block
// takes one pixel per clock unless the output stalls, through an input register and a
// result register; an empty input register takes a new pixel while a finished one
// waits. Configuration writes take effect at once and are meant for idle periods only.
module layer_pixel_source_over_blend
  import lpsob_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_W-1:0]     layer_row,
  input  logic [COORD_W-1:0]     layer_col,
  input  logic [PIX_W-1:0]       layer_pixel,
  input  logic [PIX_W-1:0]       canvas_pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   write_enable,
  output logic                   out_of_range,
  output logic [ADDR_W-1:0]      canvas_address,
  output logic [PIX_W-1:0]       blended_pixel
);

  logic signed [CFG_W-1:0] offset_col;
  logic signed [CFG_W-1:0] offset_row;
  logic [CFG_W-1:0]        canvas_width;
  logic [CFG_W-1:0]        canvas_height;

  in_item_t  s1;
  logic      s1_valid;
  logic      s1_adv;
  out_item_t res_next;
  out_item_t res;

  logic             tgt_oor;
  logic [ADDR_W-1:0] tgt_addr;
  logic [PIX_W-1:0] mix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_col    <= '0;
      offset_row    <= '0;
      canvas_width  <= CFG_W'(1);
      canvas_height <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_COL:    offset_col    <= $signed(cfg_data);
        CFG_OFFSET_ROW:    offset_row    <= $signed(cfg_data);
        CFG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas_height <= cfg_data;
      endcase
    end
  end

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.layer_row    <= layer_row;
      s1.layer_col    <= layer_col;
      s1.layer_pixel  <= layer_pixel;
      s1.canvas_pixel <= canvas_pixel;
    end
  end

  lpsob_target #(
    .MAX_DIM(MAX_DIM)
  ) u_target (
    .layer_row     (s1.layer_row),
    .layer_col     (s1.layer_col),
    .offset_row    (offset_row),
    .offset_col    (offset_col),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .out_of_range  (tgt_oor),
    .canvas_address(tgt_addr)
  );

  lpsob_blend u_blend (
    .src(s1.layer_pixel),
    .dst(s1.canvas_pixel),
    .pix(mix)
  );

  always_comb begin
    res_next.out_of_range   = tgt_oor;
    res_next.canvas_address = tgt_addr;
    res_next.write_enable   = !tgt_oor && ((s1.layer_pixel & ALPHA_MASK) != '0);
    res_next.blended_pixel  = res_next.write_enable ? mix : s1.canvas_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res <= res_next;
    end
  end

  assign write_enable   = res.write_enable;
  assign out_of_range   = res.out_of_range;
  assign canvas_address = res.canvas_address;
  assign blended_pixel  = res.blended_pixel;

`ifndef SYNTHESIS
  a_we_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_enable && out_of_range))
    else $error("Write enable raised for a target outside the canvas.");

  a_oor_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (canvas_address == '0))
    else $error("Out-of-range result carries a nonzero address.");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> out_valid)
    else $error("Item left the input register without reaching the result register.");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("Input refused while the input register is empty.");
`endif

endmodule
